[rtl/core/ffha_pkg.sv]
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;

    localparam int C_XW = 17;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_CALLOC  = 2'd2;
    localparam logic [1:0] OP_REALLOC = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef enum logic [4:0] {
        C_NOP,
        C_INIT,
        C_LOAD,
        C_MUL,
        C_RD_IDX,
        C_RD_IDX1,
        C_RD_IDXM1,
        C_NEXT,
        C_IDX0,
        C_FOUND,
        C_ALLOC_SPLIT,
        C_ALLOC_WHOLE,
        C_RD_KM1,
        C_SHIFT_UP,
        C_INS_PUT,
        C_RD_K1,
        C_SHIFT_DN,
        C_DEC,
        C_SETFREE,
        C_MERGE_FWD,
        C_MERGE_BWD,
        C_WR_CUR,
        C_SHRINK,
        C_SET_RADDR,
        C_GROW_SPLIT,
        C_GROW_ALL,
        C_MV_MARK,
        C_ST_NOFIT,
        C_ST_ZERO,
        C_EMIT
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       baddr_zero;
        logic       size_zero;
        logic       calloc_zero;
        logic       idx_lt_total;
        logic       idx1_lt_total;
        logic       idx_zero;
        logic       k_gt_ins;
        logic       k1_lt_total;
        logic       rd_match;
        logic       rd_free;
        logic       fit_split;
        logic       fit;
        logic       shrink;
        logic       shrink_split;
        logic       grow_ok;
        logic       grow_split;
        logic       out_free;
    } t_stat;

endpackage

[rtl/core/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

[rtl/core/ffha_ctrl.sv]
// Sequencer for scans, table shifts and merges of the allocator.
module ffha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd,
    output logic          o_stall
);
    import ffha_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_A_RD, S_A_CHK, S_A_DONE,
        S_F_RD, S_F_CHK, S_F_HIT, S_G_CHK,
        S_R_SET, S_R_FWD, S_R_FCHK, S_R_BWD, S_R_BCHK, S_WR_CUR,
        S_INS_RD, S_INS_WR, S_RM_RD, S_RM_WR,
        S_FINISH
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic   r_move, n_move;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_move  = r_move;
        cmd     = C_NOP;
        unique case (r_state)
            S_INIT: begin
                cmd     = C_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd     = C_LOAD;
                    n_move  = 1'b0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_ALLOC: n_state = S_A_RD;
                    OP_FREE:  n_state = i_stat.baddr_zero ? S_FINISH : S_F_RD;
                    OP_CALLOC: begin
                        if (i_stat.calloc_zero) begin
                            cmd     = C_ST_ZERO;
                            n_state = S_FINISH;
                        end else begin
                            cmd     = C_MUL;
                            n_state = S_A_RD;
                        end
                    end
                    default: n_state = i_stat.baddr_zero ? S_A_RD : S_F_RD;
                endcase
            end
            S_A_RD: begin
                if (i_stat.idx_lt_total) begin
                    cmd     = C_RD_IDX;
                    n_state = S_A_CHK;
                end else begin
                    cmd     = C_ST_NOFIT;
                    n_state = S_FINISH;
                end
            end
            S_A_CHK: begin
                priority if (i_stat.fit_split) begin
                    cmd     = C_ALLOC_SPLIT;
                    n_ret   = S_A_DONE;
                    n_state = S_INS_RD;
                end else if (i_stat.fit) begin
                    cmd     = C_ALLOC_WHOLE;
                    n_state = S_A_DONE;
                end else begin
                    cmd     = C_NEXT;
                    n_state = S_A_RD;
                end
            end
            S_A_DONE: begin
                if (r_move) begin
                    cmd     = C_MV_MARK;
                    n_state = S_F_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_F_RD: begin
                if (i_stat.idx_lt_total) begin
                    cmd     = C_RD_IDX;
                    n_state = S_F_CHK;
                end else begin
                    if (i_stat.op == OP_REALLOC) begin
                        cmd = C_ST_NOFIT;
                    end
                    n_state = S_FINISH;
                end
            end
            S_F_CHK: begin
                if (i_stat.rd_match) begin
                    cmd     = C_FOUND;
                    n_state = S_F_HIT;
                end else begin
                    cmd     = C_NEXT;
                    n_state = S_F_RD;
                end
            end
            S_F_HIT: begin
                priority if (r_move || i_stat.op == OP_FREE || i_stat.size_zero) begin
                    n_state = S_R_SET;
                end else if (i_stat.shrink) begin
                    if (i_stat.shrink_split) begin
                        cmd     = C_SHRINK;
                        n_ret   = S_FINISH;
                        n_state = S_INS_RD;
                    end else begin
                        cmd     = C_SET_RADDR;
                        n_state = S_FINISH;
                    end
                end else if (i_stat.idx1_lt_total) begin
                    cmd     = C_RD_IDX1;
                    n_state = S_G_CHK;
                end else begin
                    cmd     = C_IDX0;
                    n_move  = 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_G_CHK: begin
                priority if (i_stat.grow_ok && i_stat.grow_split) begin
                    cmd     = C_GROW_SPLIT;
                    n_state = S_WR_CUR;
                end else if (i_stat.grow_ok) begin
                    cmd     = C_GROW_ALL;
                    n_ret   = S_WR_CUR;
                    n_state = S_RM_RD;
                end else begin
                    cmd     = C_IDX0;
                    n_move  = 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_R_SET: begin
                cmd     = C_SETFREE;
                n_state = S_R_FWD;
            end
            S_R_FWD: begin
                if (i_stat.idx1_lt_total) begin
                    cmd     = C_RD_IDX1;
                    n_state = S_R_FCHK;
                end else begin
                    n_state = S_R_BWD;
                end
            end
            S_R_FCHK: begin
                if (i_stat.rd_free) begin
                    cmd     = C_MERGE_FWD;
                    n_ret   = S_R_FWD;
                    n_state = S_RM_RD;
                end else begin
                    n_state = S_R_BWD;
                end
            end
            S_R_BWD: begin
                if (!i_stat.idx_zero) begin
                    cmd     = C_RD_IDXM1;
                    n_state = S_R_BCHK;
                end else begin
                    n_state = S_WR_CUR;
                end
            end
            S_R_BCHK: begin
                if (i_stat.rd_free) begin
                    cmd     = C_MERGE_BWD;
                    n_ret   = S_R_BWD;
                    n_state = S_RM_RD;
                end else begin
                    n_state = S_WR_CUR;
                end
            end
            S_WR_CUR: begin
                cmd     = C_WR_CUR;
                n_state = S_FINISH;
            end
            S_INS_RD: begin
                if (i_stat.k_gt_ins) begin
                    cmd     = C_RD_KM1;
                    n_state = S_INS_WR;
                end else begin
                    cmd     = C_INS_PUT;
                    n_state = r_ret;
                end
            end
            S_INS_WR: begin
                cmd     = C_SHIFT_UP;
                n_state = S_INS_RD;
            end
            S_RM_RD: begin
                if (i_stat.k1_lt_total) begin
                    cmd     = C_RD_K1;
                    n_state = S_RM_WR;
                end else begin
                    cmd     = C_DEC;
                    n_state = r_ret;
                end
            end
            S_RM_WR: begin
                cmd     = C_SHIFT_DN;
                n_state = S_RM_RD;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    cmd     = C_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_FINISH;
            r_move  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_move  <= n_move;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
endmodule

[rtl/core/ffha_dp.sv]
// Datapath: block table memory, working registers and result registers.
module ffha_dp #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_stat o_stat,
    input  logic [1:0]      i_op,
    input  logic [15:0]     i_req_size,
    input  logic [15:0]     i_elem_count,
    input  logic [11:0]     i_block_addr,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [11:0]     o_result_addr,
    output logic [1:0]      o_status,
    output logic            o_moved,
    output logic [11:0]     o_copy_bytes
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int SW = AW + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int TW = $clog2(MAX_BLOCKS + 1);
    localparam logic [C_XW-1:0] HX  = C_XW'(HEADER_BYTES);
    localparam logic [C_XW-1:0] HX1 = C_XW'(HEADER_BYTES + 1);
    localparam logic [33:0]     HW  = 34'(HEADER_BYTES);

    typedef struct packed {
        logic          free;
        logic [SW-1:0] size;
        logic [AW-1:0] start;
    } t_entry;

    localparam int EW = $bits(t_entry);

    logic [1:0]    r_op;
    logic [15:0]   r_size, r_count;
    logic [11:0]   r_baddr;
    logic [31:0]   r_req;
    logic [TW-1:0] r_total, r_idx, r_k;
    t_entry        r_cur, r_ins;
    logic [SW-1:0] r_old;
    logic [11:0]   r_raddr, r_copy;
    logic [1:0]    r_status;
    logic          r_moved;
    logic          r_ovalid;
    logic [11:0]   r_o_raddr, r_o_copy;
    logic [1:0]    r_o_status;
    logic          r_o_moved;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    t_entry        wr_data;
    logic [EW-1:0] rd_raw;
    t_entry        rd;

    logic [C_XW-1:0] size_x, cur_size_x, rd_size_x, rem, comb, rest;
    logic [33:0]     req_w, rd_size_w;
    logic [TW-1:0]   idx1, idxm1, km1, k1;
    logic            full;

    ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_raw)
    );

    assign rd         = t_entry'(rd_raw);
    assign size_x     = C_XW'(r_size);
    assign cur_size_x = C_XW'(r_cur.size);
    assign rd_size_x  = C_XW'(rd.size);
    assign rem        = cur_size_x - size_x;
    assign comb       = cur_size_x + HX + rd_size_x;
    assign rest       = comb - size_x;
    assign req_w      = {2'b00, r_req};
    assign rd_size_w  = 34'(rd.size);
    assign idx1       = r_idx + TW'(1);
    assign idxm1      = r_idx - TW'(1);
    assign km1        = r_k - TW'(1);
    assign k1         = r_k + TW'(1);
    assign full       = (r_total == TW'(MAX_BLOCKS));

    always_comb begin
        o_stat.op            = r_op;
        o_stat.baddr_zero    = (r_baddr == 12'd0);
        o_stat.size_zero     = (r_size == 16'd0);
        o_stat.calloc_zero   = (r_size == 16'd0) || (r_count == 16'd0);
        o_stat.idx_lt_total  = (r_idx < r_total);
        o_stat.idx1_lt_total = ({1'b0, idx1} < {1'b0, r_total});
        o_stat.idx_zero      = (r_idx == '0);
        o_stat.k_gt_ins      = ({1'b0, r_k} > {1'b0, idx1});
        o_stat.k1_lt_total   = ({1'b0, k1} < {1'b0, r_total});
        o_stat.rd_match      = (C_XW'(rd.start) + HX) == C_XW'(r_baddr);
        o_stat.rd_free       = rd.free;
        o_stat.fit_split     = rd.free && (rd_size_w >= req_w + HW) && !full;
        o_stat.fit           = rd.free && (rd_size_w >= req_w);
        o_stat.shrink        = (size_x < cur_size_x);
        o_stat.shrink_split  = (rem >= HX1) && !full;
        o_stat.grow_ok       = rd.free && (comb >= size_x);
        o_stat.grow_split    = (rest >= HX1);
        o_stat.out_free      = !r_ovalid || !i_stall;
    end

    // Table memory access per command.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = r_cur;
        unique case (i_cmd)
            C_RD_IDX:   rd_en = 1'b1;
            C_RD_IDX1: begin
                rd_en   = 1'b1;
                rd_addr = idx1[IW-1:0];
            end
            C_RD_IDXM1: begin
                rd_en   = 1'b1;
                rd_addr = idxm1[IW-1:0];
            end
            C_RD_KM1: begin
                rd_en   = 1'b1;
                rd_addr = km1[IW-1:0];
            end
            C_RD_K1: begin
                rd_en   = 1'b1;
                rd_addr = k1[IW-1:0];
            end
            C_INIT: begin
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data.free  = 1'b1;
                wr_data.size  = SW'(HEAP_BYTES - HEADER_BYTES);
                wr_data.start = '0;
            end
            C_ALLOC_SPLIT: begin
                wr_en        = 1'b1;
                wr_data      = rd;
                wr_data.free = 1'b0;
                wr_data.size = SW'(r_req);
            end
            C_ALLOC_WHOLE: begin
                wr_en        = 1'b1;
                wr_data      = rd;
                wr_data.free = 1'b0;
            end
            C_SHIFT_UP, C_SHIFT_DN: begin
                wr_en   = 1'b1;
                wr_addr = r_k[IW-1:0];
                wr_data = rd;
            end
            C_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = idx1[IW-1:0];
                wr_data = r_ins;
            end
            C_WR_CUR: wr_en = 1'b1;
            C_SHRINK: begin
                wr_en        = 1'b1;
                wr_data.size = SW'(r_size);
            end
            C_GROW_SPLIT: begin
                wr_en         = 1'b1;
                wr_addr       = idx1[IW-1:0];
                wr_data.free  = 1'b1;
                wr_data.size  = SW'(rest - HX);
                wr_data.start = AW'(C_XW'(r_cur.start) + HX + size_x);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= TW'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == C_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd)
                C_INIT:    r_total <= TW'(1);
                C_INS_PUT: r_total <= r_total + TW'(1);
                C_DEC:     r_total <= r_total - TW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_LOAD: begin
                r_op     <= i_op;
                r_size   <= i_req_size;
                r_count  <= i_elem_count;
                r_baddr  <= i_block_addr;
                r_req    <= {16'd0, i_req_size};
                r_idx    <= '0;
                r_raddr  <= '0;
                r_status <= ST_DONE;
                r_moved  <= 1'b0;
                r_copy   <= '0;
            end
            C_MUL:  r_req <= r_size * r_count;
            C_NEXT: r_idx <= r_idx + TW'(1);
            C_IDX0: r_idx <= '0;
            C_FOUND: begin
                r_cur <= rd;
                r_old <= rd.size;
            end
            C_ALLOC_SPLIT: begin
                r_ins.free  <= 1'b1;
                r_ins.size  <= SW'(rd_size_w - req_w - HW);
                r_ins.start <= AW'(34'(rd.start) + HW + req_w);
                r_k         <= r_total;
                r_raddr     <= 12'(C_XW'(rd.start) + HX);
            end
            C_ALLOC_WHOLE: r_raddr <= 12'(C_XW'(rd.start) + HX);
            C_SHIFT_UP:    r_k <= km1;
            C_SHIFT_DN:    r_k <= k1;
            C_SETFREE:     r_cur.free <= 1'b1;
            C_MERGE_FWD: begin
                r_cur.size <= SW'(comb);
                r_k        <= idx1;
            end
            C_MERGE_BWD: begin
                r_cur.free  <= rd.free;
                r_cur.start <= rd.start;
                r_cur.size  <= SW'(comb);
                r_k         <= r_idx;
                r_idx       <= idxm1;
            end
            C_SHRINK: begin
                r_ins.free  <= 1'b1;
                r_ins.size  <= SW'(rem - HX);
                r_ins.start <= AW'(C_XW'(r_cur.start) + HX + size_x);
                r_k         <= r_total;
                r_raddr     <= r_baddr;
            end
            C_SET_RADDR: r_raddr <= r_baddr;
            C_GROW_SPLIT: begin
                r_cur.size <= SW'(r_size);
                r_raddr    <= r_baddr;
            end
            C_GROW_ALL: begin
                r_cur.size <= SW'(comb);
                r_k        <= idx1;
                r_raddr    <= r_baddr;
            end
            C_MV_MARK: begin
                r_moved <= 1'b1;
                r_copy  <= 12'(r_old);
                r_idx   <= '0;
            end
            C_ST_NOFIT: r_status <= ST_NOFIT;
            C_ST_ZERO:  r_status <= ST_ZERO;
            C_EMIT: begin
                r_o_raddr  <= r_raddr;
                r_o_status <= r_status;
                r_o_moved  <= r_moved;
                r_o_copy   <= r_copy;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_result_addr = r_o_raddr;
    assign o_status      = r_o_status;
    assign o_moved       = r_o_moved;
    assign o_copy_bytes  = r_o_copy;
endmodule

[rtl/core/first_fit_heap_allocator_core.sv]
// Operation: a transaction runs as table passes (a scan, an insert shift or a removal shift).
// The one table memory has one read port, so each entry is read in one state and then
// checked or written in another. A realloc that moves its block makes three scans and, if
// the new block is split, an insert, and a release adds one removal pass for each merged
// neighbor. A stalled result holds the block in its last state.
// Throughput: one transaction at a time. The next transaction is taken once the result is
// registered.
// Reset: synchronous, active low. After reset the S_INIT state writes the single free block,
// then the block accepts transactions.
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_elem_count,
    input  logic [11:0] i_block_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_result_addr,
    output logic [1:0]  o_status,
    output logic        o_moved,
    output logic [11:0] o_copy_bytes
);
    import ffha_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_stall(o_stall)
    );

    ffha_dp #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_op),
        .i_req_size   (i_req_size),
        .i_elem_count (i_elem_count),
        .i_block_addr (i_block_addr),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result_addr(o_result_addr),
        .o_status     (o_status),
        .o_moved      (o_moved),
        .o_copy_bytes (o_copy_bytes)
    );
endmodule
